[src/fsr_pkg.sv]
// Shared types and constants of the filled shape rasterizer.
package fsr_pkg;

  localparam int unsigned FRAME_WIDTH  = 640;
  localparam int unsigned FRAME_HEIGHT = 480;

  typedef enum logic [1:0] {
    MODE_STEP   = 2'd0,
    MODE_CIRCLE = 2'd1,
    MODE_RECT   = 2'd2
  } mode_t;

  typedef struct packed {
    logic               in_frame;
    logic               circle;
    logic               done;
    logic [10:0]        px;
    logic [10:0]        py;
    logic [15:0]        color;
    logic signed [10:0] ox;
    logic signed [10:0] oy;
    logic [9:0]         radius;
  } scan_entry_t;

  typedef struct packed {
    logic        valid;
    scan_entry_t entry;
  } queue_xfer_t;

endpackage

[src/fsr_in_if.sv]
// Command and step channel of the rasterizer.
interface fsr_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [11:0] origin_x;
  logic signed [11:0] origin_y;
  logic [9:0]         extent;
  logic [9:0]         rect_height;
  logic [15:0]        fill_color;

  modport source (output valid, mode, origin_x, origin_y, extent, rect_height, fill_color,
                  input ready);
  modport sink   (input valid, mode, origin_x, origin_y, extent, rect_height, fill_color,
                  output ready);
endinterface

[src/fsr_out_if.sv]
// Pixel result channel of the rasterizer.
interface fsr_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [10:0] pixel_x;
  logic [10:0] pixel_y;
  logic [15:0] pixel_color;
  logic        done_res;

  modport source (output valid, write_enable, pixel_x, pixel_y, pixel_color, done_res,
                  input ready);
  modport sink   (input valid, write_enable, pixel_x, pixel_y, pixel_color, done_res,
                  output ready);
endinterface

[src/filled_shape_rasterizer.sv]
// Top level of the filled circle and rectangle rasterizer.
//   channel | dir | transfer carries
//   in_ch   | in  | mode, origin_x, origin_y, extent, rect_height, fill_color
//   out_ch  | out | write_enable, pixel_x, pixel_y, pixel_color, done_res
// One item per cycle sustained while the output is not stalled; every item gives one result.
// Each item passes in order through the queue slot, the square stage and the output register.
// The scan position lives in the front end, so steps advance as soon as accepted.
// Synchronous active-low reset empties the queue and both back-end stages.
// A stalled output holds; the two-entry queue lets the front keep taking items until both slots are full.
module filled_shape_rasterizer (
  input  logic       clk,
  input  logic       rst_n,
  fsr_in_if.sink     in_ch,
  fsr_out_if.source  out_ch
);

  fsr_pkg::queue_xfer_t push;
  fsr_pkg::queue_xfer_t pop;
  logic                 push_ready;
  logic                 pop_take;

  fsr_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  fsr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_take   (pop_take)
  );

  fsr_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .pop      (pop),
    .pop_take (pop_take),
    .out_ch   (out_ch)
  );

endmodule

[src/fsr_front.sv]
// Front end: command decode, scan position tracking and frame clipping.
module fsr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  fsr_in_if.sink               in_ch,
  output fsr_pkg::queue_xfer_t push,
  input  logic                 push_ready
);

  logic               busy_r, busy_nxt;
  logic               kind_r, kind_nxt;
  logic signed [11:0] anchor_x_r, anchor_x_nxt;
  logic signed [11:0] anchor_y_r, anchor_y_nxt;
  logic [9:0]         span_x_r, span_x_nxt;
  logic [9:0]         span_y_r, span_y_nxt;
  logic [15:0]        color_r, color_nxt;
  logic signed [10:0] ox_r, ox_nxt;
  logic signed [10:0] oy_r, oy_nxt;

  logic               accept;
  logic               is_start;
  logic               is_rect;
  logic               step_active;
  logic signed [12:0] px;
  logic signed [12:0] py;
  logic               in_frame;
  logic               last_x;
  logic               last_y;
  logic signed [10:0] start_off;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid && push_ready;
  assign is_rect     = in_ch.mode == fsr_pkg::MODE_RECT;
  assign is_start    = (in_ch.mode == fsr_pkg::MODE_CIRCLE) || is_rect;
  assign step_active = (in_ch.mode == fsr_pkg::MODE_STEP) && busy_r;
  assign start_off   = is_rect ? 11'sd0 : $signed(11'd0 - {1'b0, in_ch.extent});

  assign px = $signed({anchor_x_r[11], anchor_x_r}) + $signed({{2{ox_r[10]}}, ox_r});
  assign py = $signed({anchor_y_r[11], anchor_y_r}) + $signed({{2{oy_r[10]}}, oy_r});
  assign in_frame = !px[12] && (px < $signed(13'(fsr_pkg::FRAME_WIDTH)))
                 && !py[12] && (py < $signed(13'(fsr_pkg::FRAME_HEIGHT)));
  assign last_x = ox_r >= $signed({1'b0, span_x_r});
  assign last_y = oy_r >= $signed({1'b0, span_y_r});

  always_comb begin
    push.valid          = accept;
    push.entry.in_frame = step_active && in_frame;
    push.entry.circle   = !kind_r;
    push.entry.done     = step_active && last_x && last_y;
    push.entry.px       = px[10:0];
    push.entry.py       = py[10:0];
    push.entry.color    = color_r;
    push.entry.ox       = ox_r;
    push.entry.oy       = oy_r;
    push.entry.radius   = span_x_r;
  end

  always_comb begin
    busy_nxt     = busy_r;
    kind_nxt     = kind_r;
    anchor_x_nxt = anchor_x_r;
    anchor_y_nxt = anchor_y_r;
    span_x_nxt   = span_x_r;
    span_y_nxt   = span_y_r;
    color_nxt    = color_r;
    ox_nxt       = ox_r;
    oy_nxt       = oy_r;
    if (accept && is_start) begin
      busy_nxt     = 1'b1;
      kind_nxt     = is_rect;
      anchor_x_nxt = in_ch.origin_x;
      anchor_y_nxt = in_ch.origin_y;
      span_x_nxt   = in_ch.extent;
      span_y_nxt   = is_rect ? in_ch.rect_height : in_ch.extent;
      color_nxt    = in_ch.fill_color;
      ox_nxt       = start_off;
      oy_nxt       = start_off;
    end else if (accept && step_active) begin
      if (last_x) begin
        if (last_y) begin
          busy_nxt = 1'b0;
        end else begin
          ox_nxt = kind_r ? 11'sd0 : $signed(11'd0 - {1'b0, span_x_r});
          oy_nxt = oy_r + 11'sd1;
        end
      end else begin
        ox_nxt = ox_r + 11'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    kind_r     <= kind_nxt;
    anchor_x_r <= anchor_x_nxt;
    anchor_y_r <= anchor_y_nxt;
    span_x_r   <= span_x_nxt;
    span_y_r   <= span_y_nxt;
    color_r    <= color_nxt;
    ox_r       <= ox_nxt;
    oy_r       <= oy_nxt;
  end

endmodule

[src/fsr_queue.sv]
// Two-entry queue between the front end and the pixel back end.
module fsr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsr_pkg::queue_xfer_t push,
  output logic                 push_ready,
  output fsr_pkg::queue_xfer_t pop,
  input  logic                 pop_take
);

  fsr_pkg::scan_entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = count_r != 2'd2;
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_take && (count_r != 2'd0);
  assign pop.valid  = count_r != 2'd0;
  assign pop.entry  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.entry;
    end
  end

endmodule

[src/fsr_back.sv]
// Back end: circle coverage test and registered pixel output.
module fsr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fsr_pkg::queue_xfer_t pop,
  output logic                 pop_take,
  fsr_out_if.source            out_ch
);

  logic        a_valid_r, a_valid_nxt;
  logic        a_inside_r;
  logic        a_circle_r;
  logic        a_done_r;
  logic [10:0] a_px_r;
  logic [10:0] a_py_r;
  logic [15:0] a_color_r;
  logic [19:0] a_sqx_r;
  logic [19:0] a_sqy_r;
  logic [19:0] a_rr_r;

  logic        o_valid_r, o_valid_nxt;
  logic        o_we_r;
  logic [10:0] o_px_r;
  logic [10:0] o_py_r;
  logic [15:0] o_color_r;
  logic        o_done_r;

  logic        b_ready;
  logic        a_ready;
  logic        a_load;
  logic        b_load;
  logic [9:0]  mag_x;
  logic [9:0]  mag_y;
  logic [20:0] sum_sq;
  logic        covered;
  logic        we;

  assign b_ready  = !o_valid_r || out_ch.ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign pop_take = a_ready;
  assign a_load   = pop.valid && a_ready;
  assign b_load   = a_valid_r && b_ready;

  assign mag_x = pop.entry.ox[10] ? 10'(-pop.entry.ox) : pop.entry.ox[9:0];
  assign mag_y = pop.entry.oy[10] ? 10'(-pop.entry.oy) : pop.entry.oy[9:0];

  assign sum_sq  = {1'b0, a_sqx_r} + {1'b0, a_sqy_r};
  assign covered = !a_circle_r || (sum_sq < {1'b0, a_rr_r});
  assign we      = a_inside_r && covered;

  always_comb begin
    a_valid_nxt = a_ready ? pop.valid : a_valid_r;
    o_valid_nxt = b_ready ? a_valid_r : o_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
    if (a_load) begin
      a_inside_r <= pop.entry.in_frame;
      a_circle_r <= pop.entry.circle;
      a_done_r   <= pop.entry.done;
      a_px_r     <= pop.entry.px;
      a_py_r     <= pop.entry.py;
      a_color_r  <= pop.entry.color;
      a_sqx_r    <= {10'd0, mag_x} * {10'd0, mag_x};
      a_sqy_r    <= {10'd0, mag_y} * {10'd0, mag_y};
      a_rr_r     <= {10'd0, pop.entry.radius} * {10'd0, pop.entry.radius};
    end
    if (b_load) begin
      o_we_r    <= we;
      o_px_r    <= we ? a_px_r : 11'd0;
      o_py_r    <= we ? a_py_r : 11'd0;
      o_color_r <= we ? a_color_r : 16'd0;
      o_done_r  <= a_done_r;
    end
  end

  assign out_ch.valid        = o_valid_r;
  assign out_ch.write_enable = o_we_r;
  assign out_ch.pixel_x      = o_px_r;
  assign out_ch.pixel_y      = o_py_r;
  assign out_ch.pixel_color  = o_color_r;
  assign out_ch.done_res     = o_done_r;

endmodule

[src/fsr_checker.sv]
// Port-level checks of the rasterizer and their binding to the top level.
module fsr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_enable,
  input logic [10:0] out_pixel_x,
  input logic [10:0] out_pixel_y,
  input logic [15:0] out_pixel_color
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_x) && $stable(out_pixel_y))
    else $error("stalled result changed");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |->
      out_pixel_x == 11'd0 && out_pixel_y == 11'd0 && out_pixel_color == 16'd0)
    else $error("fields set without a write");

  a_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |->
      out_pixel_x < 11'(fsr_pkg::FRAME_WIDTH) && out_pixel_y < 11'(fsr_pkg::FRAME_HEIGHT))
    else $error("write outside the frame");

endmodule

bind filled_shape_rasterizer fsr_checker u_fsr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_write_enable (out_ch.write_enable),
  .out_pixel_x      (out_ch.pixel_x),
  .out_pixel_y      (out_ch.pixel_y),
  .out_pixel_color  (out_ch.pixel_color)
);
